/* rtl/ssc_pkg.sv */
// Shared types, codes and default sizes for the sparse-set component store.
`default_nettype none

package ssc_pkg;

    // Fixed field widths of the request and result channels.
    localparam int OP_BITS     = 2;
    localparam int ID_BITS     = 10;
    localparam int STATUS_BITS = 2;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_IDS       = 1024;
    localparam int DEF_MAX_ENTRIES   = 256;
    localparam int DEF_PAYLOAD_WIDTH = 64;

    typedef logic [OP_BITS-1:0]     t_op;
    typedef logic [ID_BITS-1:0]     t_id;
    typedef logic [STATUS_BITS-1:0] t_status;

    // Operation codes.
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_LOOKUP = 2'd2;

    // Result status codes.
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_PRESENT   = 2'd3;

    // Head of the request queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_op  op;
        t_id  id;
        logic in_range;
    } t_item_hdr;

    // Control from the back end to the front end.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

endpackage

`default_nettype wire

/* rtl/ssc_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none

module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One access per cycle: write, or read with the data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

/* rtl/ssc_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module ssc_front
    import ssc_pkg::*;
#(
    parameter int MAX_IDS       = DEF_MAX_IDS,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire t_op                      i_op,
    input  wire t_id                      i_entity_id,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_payload_in,
    output t_item_hdr                     o_hdr,
    output logic      [PAYLOAD_WIDTH-1:0] o_payload,
    input  wire t_back_ctl                i_ctl
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    logic                     r_in_range [QDEPTH];
    t_op                      r_q_op     [QDEPTH];
    t_id                      r_q_id     [QDEPTH];
    logic [PAYLOAD_WIDTH-1:0] r_q_pay    [QDEPTH];
    logic [QAW-1:0]           r_wr_ptr;
    logic [QAW-1:0]           r_rd_ptr;
    logic [QAW:0]             r_fill;
    logic                     accept;
    t_op                      norm_op;
    logic                     in_range;

    // The unused op code behaves as a lookup.
    always_comb begin
        case (i_op)
            OP_INSERT: norm_op = OP_INSERT;
            OP_REMOVE: norm_op = OP_REMOVE;
            default:   norm_op = OP_LOOKUP;
        endcase
    end

    // Ids beyond the map are never present.
    assign in_range = (32'(i_entity_id) < MAX_IDS);

    // Requests are held off while the queue is full or the map is being cleared.
    assign o_ready = (r_fill != (QAW+1)'(QDEPTH)) && !i_ctl.clearing;
    assign accept  = i_valid && o_ready;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_range[r_wr_ptr] <= in_range;
            r_q_op[r_wr_ptr]     <= norm_op;
            r_q_id[r_wr_ptr]     <= i_entity_id;
            r_q_pay[r_wr_ptr]    <= i_payload_in;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_ctl.pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({accept, i_ctl.pop})
                2'b10:   r_fill <= r_fill + (QAW+1)'(1);
                2'b01:   r_fill <= r_fill - (QAW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    // Head of the queue.
    assign o_hdr.valid    = (r_fill != '0);
    assign o_hdr.op       = r_q_op[r_rd_ptr];
    assign o_hdr.id       = r_q_id[r_rd_ptr];
    assign o_hdr.in_range = r_in_range[r_rd_ptr];
    assign o_payload      = r_q_pay[r_rd_ptr];

endmodule

`default_nettype wire

/* rtl/ssc_back.sv */
// Back end: sequencer that carries out requests on the map and dense memories.
`default_nettype none

module ssc_back
    import ssc_pkg::*;
#(
    parameter int MAX_IDS       = DEF_MAX_IDS,
    parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire t_item_hdr                            i_hdr,
    input  wire logic [PAYLOAD_WIDTH-1:0]             i_payload,
    output t_back_ctl                                 o_ctl,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output t_status                                   o_status,
    output logic                                      o_found,
    output logic [PAYLOAD_WIDTH-1:0]                  o_payload_out,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]          o_entry_count
);

    localparam int MAP_AW = $clog2(MAX_IDS);
    localparam int ENT_AW = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES+1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MAP   = 3'd2;
    localparam logic [2:0] S_LOOK  = 3'd3;
    localparam logic [2:0] S_MOVE  = 3'd4;
    localparam logic [2:0] S_FIX   = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [MAP_AW-1:0]        r_clr, n_clr;
    logic [CNT_W-1:0]         r_count, n_count;
    t_op                      r_op, n_op;
    t_id                      r_id, n_id;
    logic                     r_in_range, n_in_range;
    logic [PAYLOAD_WIDTH-1:0] r_pay, n_pay;
    logic [ENT_AW-1:0]        r_slot, n_slot;
    logic [PAYLOAD_WIDTH-1:0] r_pout, n_pout;
    logic                     r_o_valid, n_o_valid;
    t_status                  r_o_status, n_o_status;
    logic                     r_o_found, n_o_found;
    logic [PAYLOAD_WIDTH-1:0] r_o_pay, n_o_pay;
    logic [CNT_W-1:0]         r_o_count, n_o_count;

    logic                     map_we;
    logic [MAP_AW-1:0]        map_addr;
    logic [CNT_W-1:0]         map_wdata;
    logic [CNT_W-1:0]         map_rdata;
    logic                     pay_we;
    logic [ENT_AW-1:0]        pay_addr;
    logic [PAYLOAD_WIDTH-1:0] pay_wdata;
    logic [PAYLOAD_WIDTH-1:0] pay_rdata;
    logic                     own_we;
    logic [ENT_AW-1:0]        own_addr;
    t_id                      own_wdata;
    t_id                      own_rdata;

    logic                     pop;
    logic                     present;
    logic [ENT_AW-1:0]        map_slot;
    logic [ENT_AW-1:0]        last_slot;
    logic                     full;

    // Map entry holds slot+1, zero meaning absent.
    assign present   = r_in_range && (map_rdata != '0);
    assign map_slot  = ENT_AW'(map_rdata - CNT_W'(1));
    assign last_slot = ENT_AW'(r_count - CNT_W'(1));
    assign full      = (r_count == CNT_W'(MAX_ENTRIES));

    // Sequencer and memory port control.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_count    = r_count;
        n_op       = r_op;
        n_id       = r_id;
        n_in_range = r_in_range;
        n_pay      = r_pay;
        n_slot     = r_slot;
        n_pout     = r_pout;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_pay    = r_o_pay;
        n_o_count  = r_o_count;
        map_we     = 1'b0;
        map_addr   = MAP_AW'(r_id);
        map_wdata  = '0;
        pay_we     = 1'b0;
        pay_addr   = r_slot;
        pay_wdata  = r_pay;
        own_we     = 1'b0;
        own_addr   = r_slot;
        own_wdata  = r_id;
        pop        = 1'b0;

        case (r_state)
            S_CLEAR: begin
                map_we   = 1'b1;
                map_addr = r_clr;
                n_clr    = r_clr + MAP_AW'(1);
                if (r_clr == MAP_AW'(MAX_IDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // Start a request only when the result register will be free.
                map_addr = MAP_AW'(i_hdr.id);
                if (i_hdr.valid && (!r_o_valid || i_out_ready)) begin
                    pop        = 1'b1;
                    n_op       = i_hdr.op;
                    n_id       = i_hdr.id;
                    n_in_range = i_hdr.in_range;
                    n_pay      = i_payload;
                    n_state    = S_MAP;
                end
            end
            S_MAP: begin
                n_slot    = map_slot;
                n_o_found = present;
                n_o_pay   = '0;
                n_o_count = r_count;
                case (r_op)
                    OP_INSERT: begin
                        n_o_valid = 1'b1;
                        n_state   = S_IDLE;
                        if (!r_in_range) begin
                            n_o_status = ST_NOT_FOUND;
                        end else if (present) begin
                            n_o_status = ST_PRESENT;
                        end else if (full) begin
                            n_o_status = ST_FULL;
                        end else begin
                            // Append at the end of the dense array.
                            pay_we     = 1'b1;
                            pay_addr   = ENT_AW'(r_count);
                            own_we     = 1'b1;
                            own_addr   = ENT_AW'(r_count);
                            map_we     = 1'b1;
                            map_wdata  = r_count + CNT_W'(1);
                            n_count    = r_count + CNT_W'(1);
                            n_o_count  = r_count + CNT_W'(1);
                            n_o_status = ST_OK;
                        end
                    end
                    OP_REMOVE: begin
                        if (!present) begin
                            n_o_valid  = 1'b1;
                            n_o_status = ST_NOT_FOUND;
                            n_state    = S_IDLE;
                        end else begin
                            // Read the removed payload and the last entry's owner.
                            pay_addr = map_slot;
                            own_addr = last_slot;
                            n_state  = S_MOVE;
                        end
                    end
                    OP_LOOKUP: begin
                        if (!present) begin
                            n_o_valid  = 1'b1;
                            n_o_status = ST_NOT_FOUND;
                            n_state    = S_IDLE;
                        end else begin
                            pay_addr = map_slot;
                            n_state  = S_LOOK;
                        end
                    end
                    default: begin
                        n_o_valid  = 1'b1;
                        n_o_status = ST_NOT_FOUND;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_LOOK: begin
                n_o_valid  = 1'b1;
                n_o_status = ST_OK;
                n_o_pay    = pay_rdata;
                n_state    = S_IDLE;
            end
            S_MOVE: begin
                // Keep the removed payload, read the last payload, repoint its owner.
                n_pout    = pay_rdata;
                pay_addr  = last_slot;
                own_we    = 1'b1;
                own_addr  = r_slot;
                own_wdata = own_rdata;
                map_we    = 1'b1;
                map_addr  = MAP_AW'(own_rdata);
                map_wdata = CNT_W'(r_slot) + CNT_W'(1);
                n_state   = S_FIX;
            end
            S_FIX: begin
                // Move the last payload into the freed slot and clear the removed id.
                pay_we     = 1'b1;
                pay_addr   = r_slot;
                pay_wdata  = pay_rdata;
                map_we     = 1'b1;
                map_addr   = MAP_AW'(r_id);
                map_wdata  = '0;
                n_count    = r_count - CNT_W'(1);
                n_o_valid  = 1'b1;
                n_o_status = ST_OK;
                n_o_pay    = r_pout;
                n_o_count  = r_count - CNT_W'(1);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_in_range <= n_in_range;
        r_pay      <= n_pay;
        r_slot     <= n_slot;
        r_pout     <= n_pout;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_pay    <= n_o_pay;
        r_o_count  <= n_o_count;
    end

    // Id to slot+1 map.
    ssc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_IDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_addr  (map_addr),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata)
    );

    // Dense payload words.
    ssc_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (MAX_ENTRIES)
    ) u_pay (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_addr  (pay_addr),
        .i_wdata (pay_wdata),
        .o_rdata (pay_rdata)
    );

    // Owning id of each dense slot.
    ssc_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_own (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_addr  (own_addr),
        .i_wdata (own_wdata),
        .o_rdata (own_rdata)
    );

    assign o_ctl.pop      = pop;
    assign o_ctl.clearing = (r_state == S_CLEAR);
    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_found        = r_o_found;
    assign o_payload_out  = r_o_pay;
    assign o_entry_count  = r_o_count;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    // A request starts only when its result has a free register.
    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (!r_o_valid || i_out_ready))
        else $error("request started while result register busy");

    // No request starts during the map clearing pass.
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !pop)
        else $error("request started during clearing");

    // A remove only finishes on a non-empty store.
    a_fix_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> (r_count != '0))
        else $error("remove on empty store");

    // A successful insert grows the store by one entry.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP && map_we) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the store");

endmodule

`default_nettype wire

/* rtl/sparse_set_component_store_unit.sv */
// Top level of the sparse-set component store: front end queue and back end sequencer.
// Maps entity ids to a packed array of payload words in single-port memories. After
// reset the id map is swept clear over all MAX_IDS entries, during which o_ready is low.
// A request is taken into a two-entry queue in the cycle it is accepted; the back end
// then reads the map entry, which settles an insert or a failed lookup or remove; a
// successful lookup then reads its payload, and a successful remove moves the last
// entry into the freed slot; one access per memory and cycle. The result is held in an
// output register until taken; requests still queue while it waits, if there is room.
`default_nettype none

module sparse_set_component_store_unit
    import ssc_pkg::*;
#(
    parameter int MAX_IDS       = DEF_MAX_IDS,
    parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire t_op                                 i_op,
    input  wire t_id                                 i_entity_id,
    input  wire logic [PAYLOAD_WIDTH-1:0]            i_payload_in,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output t_status                                  o_status,
    output logic                                     o_found,
    output logic [PAYLOAD_WIDTH-1:0]                 o_payload_out,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]         o_entry_count
);

    t_item_hdr                hdr;
    logic [PAYLOAD_WIDTH-1:0] q_payload;
    t_back_ctl                ctl;

    // Request intake and queue.
    ssc_front #(
        .MAX_IDS       (MAX_IDS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_entity_id  (i_entity_id),
        .i_payload_in (i_payload_in),
        .o_hdr        (hdr),
        .o_payload    (q_payload),
        .i_ctl        (ctl)
    );

    // Execution on the memories and result register.
    ssc_back #(
        .MAX_IDS       (MAX_IDS),
        .MAX_ENTRIES   (MAX_ENTRIES),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hdr         (hdr),
        .i_payload     (q_payload),
        .o_ctl         (ctl),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_payload_out (o_payload_out),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

/* dv/tb_sparse_set_component_store_unit.sv */
// Self-checking testbench for the sparse-set component store with a built-in store predictor.
module tb_sparse_set_component_store_unit;
    import ssc_pkg::*;

    localparam int N_IDS   = DEF_MAX_IDS;
    localparam int N_SLOTS = DEF_MAX_ENTRIES;
    localparam int PW      = DEF_PAYLOAD_WIDTH;
    localparam int CW      = $clog2(DEF_MAX_ENTRIES + 1);

    // Code 3 is not named by the package; the block decodes it as a lookup.
    localparam t_op OP_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_AFTER   = 420;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;

    typedef logic [PW-1:0] t_word;
    typedef logic [CW-1:0] t_count;

    typedef struct packed {
        t_status status;
        logic    found;
        t_word   payload;
        t_count  count;
    } t_result;

    typedef struct packed {
        t_op     op;
        t_id     id;
        t_word   payload;
        logic    typed;
        t_result want;
    } t_row;

    localparam t_word ONES = {PW{1'b1}};
    localparam t_word PA   = 64'hA5A5_A5A5_A5A5_A5A5;
    localparam t_word PB   = 64'h5A5A_5A5A_5A5A_5A5A;
    localparam t_word PC   = 64'h8000_0000_0000_0001;
    localparam t_word PD   = 64'h0123_4567_89AB_CDEF;

    // Directed requests; rows with typed set carry their expected result.
    localparam t_row DIRECTED [0:24] = '{
        '{OP_LOOKUP, 10'd0,    64'd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 9'd0}},
        '{OP_REMOVE, 10'd1023, 64'd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 9'd0}},
        '{OP_SPARE,  10'd5,    ONES,  1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 9'd0}},
        '{OP_INSERT, 10'd0,    ONES,  1'b1, '{ST_OK,        1'b0, 64'd0, 9'd1}},
        '{OP_INSERT, 10'd1023, 64'd0, 1'b1, '{ST_OK,        1'b0, 64'd0, 9'd2}},
        '{OP_INSERT, 10'd0,    PD,    1'b1, '{ST_PRESENT,   1'b1, 64'd0, 9'd2}},
        '{OP_LOOKUP, 10'd0,    64'd0, 1'b1, '{ST_OK,        1'b1, ONES,  9'd2}},
        '{OP_SPARE,  10'd1023, ONES,  1'b1, '{ST_OK,        1'b1, 64'd0, 9'd2}},
        '{OP_INSERT, 10'd512,  PA,    1'b1, '{ST_OK,        1'b0, 64'd0, 9'd3}},
        '{OP_INSERT, 10'd1,    PB,    1'b1, '{ST_OK,        1'b0, 64'd0, 9'd4}},
        '{OP_REMOVE, 10'd0,    ONES,  1'b1, '{ST_OK,        1'b1, ONES,  9'd3}},
        '{OP_LOOKUP, 10'd1,    64'd0, 1'b1, '{ST_OK,        1'b1, PB,    9'd3}},
        '{OP_LOOKUP, 10'd0,    64'd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 9'd3}},
        '{OP_REMOVE, 10'd512,  64'd0, 1'b1, '{ST_OK,        1'b1, PA,    9'd2}},
        '{OP_LOOKUP, 10'd512,  64'd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 9'd2}},
        '{OP_REMOVE, 10'd1023, 64'd0, 1'b1, '{ST_OK,        1'b1, 64'd0, 9'd1}},
        '{OP_REMOVE, 10'd1,    64'd0, 1'b1, '{ST_OK,        1'b1, PB,    9'd0}},
        '{OP_LOOKUP, 10'd1,    64'd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 9'd0}},
        '{OP_REMOVE, 10'd1,    64'd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 9'd0}},
        '{OP_INSERT, 10'd1,    PC,    1'b1, '{ST_OK,        1'b0, 64'd0, 9'd1}},
        '{OP_INSERT, 10'd700,  PD,    1'b0, '0},
        '{OP_REMOVE, 10'd1,    ONES,  1'b0, '0},
        '{OP_LOOKUP, 10'd700,  64'd0, 1'b0, '0},
        '{OP_INSERT, 10'd1,    ONES,  1'b0, '0},
        '{OP_SPARE,  10'd700,  64'd0, 1'b0, '0}
    };

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_ready;
    t_op     i_op = OP_LOOKUP;
    t_id     i_entity_id = '0;
    t_word   i_payload_in = '0;
    logic    o_valid;
    logic    i_ready = 1'b0;
    t_status o_status;
    logic    o_found;
    t_word   o_payload_out;
    t_count  o_entry_count;

    // Predicted contents of the store.
    t_word   payload_at [N_SLOTS];
    t_id     owner_at [N_SLOTS];
    t_count  slot_of_id [N_IDS];
    int      held_entries = 0;

    t_result pending_results [$];
    int      fail_count = 0;
    int      result_index = 0;
    int      accepted_count = 0;
    logic    sink_hold = 1'b0;
    bit      filling = 1'b1;
    int      full_dwell = 0;

    sparse_set_component_store_unit #(
        .MAX_IDS       (N_IDS),
        .MAX_ENTRIES   (N_SLOTS),
        .PAYLOAD_WIDTH (PW)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_entity_id   (i_entity_id),
        .i_payload_in  (i_payload_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_payload_out (o_payload_out),
        .o_entry_count (o_entry_count)
    );

    always #4 i_clk = ~i_clk;

    // Applies one request to the predicted store and returns its result.
    function automatic t_result store_step(t_op op, t_id id, t_word pay);
        t_result r;
        logic    present;
        int      slot;
        int      last;
        t_id     moved_id;
        r = '0;
        present = (slot_of_id[id] != 0) && (int'(slot_of_id[id]) <= held_entries);
        slot = present ? int'(slot_of_id[id]) - 1 : 0;
        r.found = present;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (present) begin
                    r.status = ST_PRESENT;
                end else if (held_entries >= N_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    payload_at[held_entries] = pay;
                    owner_at[held_entries] = id;
                    held_entries++;
                    slot_of_id[id] = t_count'(held_entries);
                end
            end
            OP_REMOVE: begin
                if (!present) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    // The last entry fills the hole; when it is the removed one,
                    // its map entry is cleared below anyway.
                    last = held_entries - 1;
                    moved_id = owner_at[last];
                    r.payload = payload_at[slot];
                    payload_at[slot] = payload_at[last];
                    owner_at[slot] = moved_id;
                    slot_of_id[moved_id] = t_count'(slot + 1);
                    slot_of_id[id] = '0;
                    held_entries = last;
                end
            end
            default: begin
                // Lookup, and the spare code that decodes as one.
                if (!present)
                    r.status = ST_NOT_FOUND;
                else
                    r.payload = payload_at[slot];
            end
        endcase
        r.count = t_count'(held_entries);
        return r;
    endfunction

    // Appends one expected result behind the ones already waiting.
    function automatic void expect_result(t_result want);
        pending_results = {pending_results, want};
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random request shaped to fill the store to full, dwell there, then drain it.
    task automatic make_random_request(output t_op op, output t_id id, output t_word pay);
        int r;
        if (filling && held_entries >= N_SLOTS) begin
            full_dwell++;
            if (full_dwell > 12) begin
                filling = 1'b0;
                full_dwell = 0;
            end
        end else if (!filling && held_entries == 0) begin
            filling = 1'b1;
        end

        r = $urandom_range(0, 99);
        if (filling)
            op = (r < 70) ? OP_INSERT : (r < 82) ? OP_REMOVE : (r < 94) ? OP_LOOKUP : OP_SPARE;
        else
            op = (r < 12) ? OP_INSERT : (r < 72) ? OP_REMOVE : (r < 94) ? OP_LOOKUP : OP_SPARE;

        // Mostly address ids that are held, so removes and lookups hit.
        r = $urandom_range(0, 99);
        if (held_entries > 0 && ((op != OP_INSERT && r < 80) || (op == OP_INSERT && r < 8)))
            id = owner_at[$urandom_range(0, held_entries - 1)];
        else if (r >= 95)
            id = '0;
        else if (r >= 90)
            id = '1;
        else
            id = t_id'($urandom_range(0, N_IDS - 1));

        r = $urandom_range(0, 99);
        if (r < 6)
            pay = '0;
        else if (r < 12)
            pay = ONES;
        else
            pay = t_word'({$urandom, $urandom});
    endtask

    // Offers one request and returns at the edge where it is accepted.
    task automatic offer_request(t_op op, t_id id, t_word pay);
        i_valid <= 1'b1;
        i_op <= op;
        i_entity_id <= id;
        i_payload_in <= pay;
        do @(posedge i_clk); while (!o_ready);
        accepted_count++;
    endtask

    // Compares one taken result with the oldest expectation.
    task automatic take_result();
        t_result got;
        t_result want;
        got = '{o_status, o_found, o_payload_out, o_entry_count};
        result_index++;
        if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("result %0d arrived with nothing expected", result_index);
        end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("result %0d: expected status %0d found %0d payload %h count %0d",
                             result_index, want.status, want.found, want.payload, want.count);
                    $display("result %0d:   actual status %0d found %0d payload %h count %0d",
                             result_index, got.status, got.found, got.payload, got.count);
                end
            end
        end
    endtask

    // Result side: random ready with calm stretches, forced low during the hold-off.
    initial begin : result_sink
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (i_rst_n && o_valid && i_ready)
                take_result();
            if (sink_hold) begin
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap((cyc / 400) % 4 == 3);
            end
        end
    end

    // Long hold-off on the result side so the block backs up and stalls requests.
    initial begin : sink_hold_off
        @(posedge i_clk);
        while (accepted_count < HOLD_AFTER)
            @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Request side: reset, directed table, then the random part.
    initial begin : request_source
        t_op     op;
        t_id     id;
        t_word   pay;
        t_result predicted;
        int      gap;
        for (int k = 0; k < N_IDS; k++)
            slot_of_id[k] = '0;
        for (int k = 0; k < N_SLOTS; k++) begin
            payload_at[k] = '0;
            owner_at[k] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < $size(DIRECTED) + RANDOM_ITEMS; n++) begin
            if (n < $size(DIRECTED)) begin
                op = DIRECTED[n].op;
                id = DIRECTED[n].id;
                pay = DIRECTED[n].payload;
            end else begin
                make_random_request(op, id, pay);
            end
            offer_request(op, id, pay);
            predicted = store_step(op, id, pay);
            if (n < $size(DIRECTED) && DIRECTED[n].typed)
                expect_result(DIRECTED[n].want);
            else
                expect_result(predicted);

            // Gap before the next request; some stretches run back to back.
            gap = pick_gap((n / 150) % 3 == 2);
            if (gap > 0 || n == $size(DIRECTED) + RANDOM_ITEMS - 1) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
